// ----- sv/bps_pkg.sv -----
// ----------------------------------------------------------------------------
// bps_pkg: shared constants for the bilinear pixel sampler
// Image store geometry, fixed-point format, datapath widths and codes.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;

  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int COORD_W = 17;                    // signed sample coordinate
  localparam int INT_W   = COORD_W - 1 - FRAC_BITS;
  localparam int DIM_W   = 9;                     // size registers
  localparam int CMP_W   = 17;                    // common width for bound compares

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int WF_W  = FRAC_BITS + 1;           // one-axis weight, 0..ONE
  localparam int WT_W  = 2 * FRAC_BITS + 1;       // tap weight, 0..ONE*ONE
  localparam int ACC_W = WT_W + CHAN_W;

  localparam logic [WF_W-1:0]  ONE_FX = WF_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF2  = ACC_W'(1) << (2 * FRAC_BITS - 1);

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam int                 CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

endpackage

// ----- sv/bps_in_if.sv -----
// ----------------------------------------------------------------------------
// bps_in_if: command word channel
// Valid/ready channel carrying a pixel write or a sample request.
// ----------------------------------------------------------------------------
interface bps_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [bps_pkg::CHAN_W-1:0]          pixel_x;
  logic [bps_pkg::CHAN_W-1:0]          pixel_y;
  logic [bps_pkg::CHAN_W-1:0]          pixel_red;
  logic [bps_pkg::CHAN_W-1:0]          pixel_green;
  logic [bps_pkg::CHAN_W-1:0]          pixel_blue;
  logic signed [bps_pkg::COORD_W-1:0]  sample_x;
  logic signed [bps_pkg::COORD_W-1:0]  sample_y;

  modport source (output valid, operation, pixel_x, pixel_y, pixel_red, pixel_green,
                  pixel_blue, sample_x, sample_y, input ready);
  modport sink   (input valid, operation, pixel_x, pixel_y, pixel_red, pixel_green,
                  pixel_blue, sample_x, sample_y, output ready);
endinterface

// ----- sv/bps_out_if.sv -----
// ----------------------------------------------------------------------------
// bps_out_if: sampled color channel
// Valid/ready channel carrying one interpolated RGB word and outside flag.
// ----------------------------------------------------------------------------
interface bps_out_if;
  logic                       valid;
  logic                       ready;
  logic [bps_pkg::CHAN_W-1:0] out_red;
  logic [bps_pkg::CHAN_W-1:0] out_green;
  logic [bps_pkg::CHAN_W-1:0] out_blue;
  logic                       out_outside;

  modport source (output valid, out_red, out_green, out_blue, out_outside, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_outside, output ready);
endinterface

// ----- sv/bilinear_pixel_sampler_unit.sv -----
// Flow: a write word is stored at its accept edge and yields nothing. A sample word
//   passes S_READ, S_DRAIN and S_FINISH into the output register (a point outside
//   the image goes straight to S_FINISH). One write per cycle while idle; a sample holds
//   off new words until done; its four neighbor reads share the single image port and MAC.
// Reset (rst, synchronous): sequencer idle, no result pending, size registers 256x256.
//   The image memory is not cleared; pixels are undefined until written.
// ----------------------------------------------------------------------------
// bilinear_pixel_sampler_unit: bilinear sampler over a stored RGB888 image
// Stores pixels on write words and returns a rounded bilinear blend of the
// four neighbors on sample words, using one shared 3-lane multiply-accumulate.
// ----------------------------------------------------------------------------
module bilinear_pixel_sampler_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bps_pkg::DIM_W-1:0]       cfg_data,
  bps_in_if.sink                          in_ch,
  bps_out_if.source                       out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,    // waiting for a word
    S_READ,    // step one neighbor tap per cycle, reading it unless skipped
    S_DRAIN,   // last tap still in the MAC
    S_FINISH   // round, saturate, hand to output register
  } state_t;

  state_t state;

  // Size registers
  logic [bps_pkg::DIM_W-1:0] image_width;
  logic [bps_pkg::DIM_W-1:0] image_height;

  // Per-sample context
  logic [bps_pkg::INT_W-1:0]     x0, y0;
  logic [bps_pkg::FRAC_BITS-1:0] dx, dy;
  logic                          xedge, yedge, outside;
  logic [1:0]                    tap;     // bit 0: +1 in x, bit 1: +1 in y

  // Shared MAC: one weight times three channel lanes
  logic [bps_pkg::WT_W-1:0]  mac_w;
  logic                      mac_v, mac_en;
  logic [bps_pkg::ACC_W-1:0] acc_r, acc_g, acc_b;

  // Image memory
  logic [bps_pkg::PIX_W-1:0] mem [bps_pkg::DEPTH];
  logic [bps_pkg::PIX_W-1:0] rdata;
  logic [bps_pkg::ADDR_W-1:0] mem_addr, wr_addr, rd_addr;
  logic mem_we, mem_rd;

  // --------------------------------------------------------------------------
  // Accept-side decode
  // --------------------------------------------------------------------------
  logic                          in_fire;
  logic [bps_pkg::CMP_W-1:0]     w_sat, h_sat, s_xc, s_yc;
  logic [bps_pkg::INT_W-1:0]     s_x0, s_y0;
  logic [bps_pkg::FRAC_BITS-1:0] s_dx, s_dy;
  logic                          s_outside, s_xedge, s_yedge, wr_ok;

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Sizes above the store saturate to the store
  assign w_sat = (bps_pkg::CMP_W'(image_width) > bps_pkg::CMP_W'(bps_pkg::MAX_WIDTH)) ?
                 bps_pkg::CMP_W'(bps_pkg::MAX_WIDTH) : bps_pkg::CMP_W'(image_width);
  assign h_sat = (bps_pkg::CMP_W'(image_height) > bps_pkg::CMP_W'(bps_pkg::MAX_HEIGHT)) ?
                 bps_pkg::CMP_W'(bps_pkg::MAX_HEIGHT) : bps_pkg::CMP_W'(image_height);

  // Floor is the integer field, fraction the low bits
  assign s_x0 = in_ch.sample_x[bps_pkg::COORD_W-2:bps_pkg::FRAC_BITS];
  assign s_y0 = in_ch.sample_y[bps_pkg::COORD_W-2:bps_pkg::FRAC_BITS];
  assign s_dx = in_ch.sample_x[bps_pkg::FRAC_BITS-1:0];
  assign s_dy = in_ch.sample_y[bps_pkg::FRAC_BITS-1:0];
  assign s_xc = bps_pkg::CMP_W'(s_x0);
  assign s_yc = bps_pkg::CMP_W'(s_y0);

  // Negative coordinate or floor past the size: outside. Zero size lands here too.
  assign s_outside = in_ch.sample_x[bps_pkg::COORD_W-1] | in_ch.sample_y[bps_pkg::COORD_W-1] |
                     (s_xc >= w_sat) | (s_yc >= h_sat);
  assign s_xedge   = (s_xc == w_sat - bps_pkg::CMP_W'(1));
  assign s_yedge   = (s_yc == h_sat - bps_pkg::CMP_W'(1));

  assign wr_ok = (bps_pkg::CMP_W'(in_ch.pixel_x) < bps_pkg::CMP_W'(bps_pkg::MAX_WIDTH)) &&
                 (bps_pkg::CMP_W'(in_ch.pixel_y) < bps_pkg::CMP_W'(bps_pkg::MAX_HEIGHT));
  assign wr_addr = bps_pkg::ADDR_W'(in_ch.pixel_y) * bps_pkg::ADDR_W'(bps_pkg::MAX_WIDTH) +
                   bps_pkg::ADDR_W'(in_ch.pixel_x);

  // --------------------------------------------------------------------------
  // Tap issue: address and weight for the current neighbor
  // Edge columns/rows force the fraction to zero, which turns the four-tap
  // blend into the exact two-tap (or pass-through) result; the taps that
  // would fall off the image are skipped and carry zero weight.
  // --------------------------------------------------------------------------
  logic                       tap_en;
  logic [bps_pkg::WF_W-1:0]   wx, wy;
  logic [2*bps_pkg::WF_W-1:0] wprod;
  logic [bps_pkg::WT_W-1:0]   tap_wt;
  logic [bps_pkg::ADDR_W-1:0] rx, ry;

  assign tap_en = !(tap[0] && xedge) && !(tap[1] && yedge);
  assign wx     = tap[0] ? {1'b0, dx} : bps_pkg::ONE_FX - {1'b0, dx};
  assign wy     = tap[1] ? {1'b0, dy} : bps_pkg::ONE_FX - {1'b0, dy};
  assign wprod  = wx * wy;
  assign tap_wt = tap_en ? wprod[bps_pkg::WT_W-1:0] : '0;

  assign rx      = bps_pkg::ADDR_W'(x0) + bps_pkg::ADDR_W'(tap[0]);
  assign ry      = bps_pkg::ADDR_W'(y0) + bps_pkg::ADDR_W'(tap[1]);
  assign rd_addr = ry * bps_pkg::ADDR_W'(bps_pkg::MAX_WIDTH) + rx;

  assign mem_we   = in_fire && (in_ch.operation == bps_pkg::OP_WRITE) && wr_ok;
  assign mem_rd   = (state == S_READ) && tap_en;
  assign mem_addr = mem_we ? wr_addr : rd_addr;

  // Single-port image memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {in_ch.pixel_red, in_ch.pixel_green, in_ch.pixel_blue};
    end
    if (mem_rd) begin
      rdata <= mem[mem_addr];
    end
  end

  // --------------------------------------------------------------------------
  // MAC lanes; a skipped tap contributes nothing
  // --------------------------------------------------------------------------
  logic [bps_pkg::CHAN_W-1:0] pr, pg, pb;
  logic [bps_pkg::ACC_W-1:0]  prod_r, prod_g, prod_b;

  assign pr = mac_en ? rdata[3*bps_pkg::CHAN_W-1:2*bps_pkg::CHAN_W] : '0;
  assign pg = mac_en ? rdata[2*bps_pkg::CHAN_W-1:bps_pkg::CHAN_W]   : '0;
  assign pb = mac_en ? rdata[bps_pkg::CHAN_W-1:0]                   : '0;

  assign prod_r = bps_pkg::ACC_W'(mac_w) * bps_pkg::ACC_W'(pr);
  assign prod_g = bps_pkg::ACC_W'(mac_w) * bps_pkg::ACC_W'(pg);
  assign prod_b = bps_pkg::ACC_W'(mac_w) * bps_pkg::ACC_W'(pb);

  // Drop the 2*FRAC_BITS fraction (half already in the accumulator), clamp to 255
  function automatic logic [bps_pkg::CHAN_W-1:0] round_sat(input logic [bps_pkg::ACC_W-1:0] a);
    logic [bps_pkg::ACC_W-2*bps_pkg::FRAC_BITS-1:0] q;
    q = a[bps_pkg::ACC_W-1:2*bps_pkg::FRAC_BITS];
    if (q[bps_pkg::ACC_W-2*bps_pkg::FRAC_BITS-1:bps_pkg::CHAN_W] != '0) begin
      return '1;
    end
    return q[bps_pkg::CHAN_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Sequencer, config registers and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_ch.valid <= 1'b0;
      mac_v        <= 1'b0;
      image_width  <= bps_pkg::DIM_RESET;
      image_height <= bps_pkg::DIM_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bps_pkg::CFG_WIDTH:  image_width  <= cfg_data;
          bps_pkg::CFG_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end

      // a finishing sample reloads the register itself in the same cycle
      if (out_ch.valid && out_ch.ready && (state != S_FINISH)) begin
        out_ch.valid <= 1'b0;
      end

      mac_v  <= (state == S_READ);
      mac_w  <= tap_wt;
      mac_en <= tap_en;
      if (mac_v) begin
        acc_r <= acc_r + prod_r;
        acc_g <= acc_g + prod_g;
        acc_b <= acc_b + prod_b;
      end

      case (state)
        S_IDLE: begin
          if (in_fire && (in_ch.operation == bps_pkg::OP_SAMPLE)) begin
            x0      <= s_x0;
            y0      <= s_y0;
            dx      <= s_xedge ? '0 : s_dx;
            dy      <= s_yedge ? '0 : s_dy;
            xedge   <= s_xedge;
            yedge   <= s_yedge;
            outside <= s_outside;
            acc_r   <= bps_pkg::HALF2;
            acc_g   <= bps_pkg::HALF2;
            acc_b   <= bps_pkg::HALF2;
            tap     <= 2'd0;
            state   <= s_outside ? S_FINISH : S_READ;
          end
        end
        S_READ: begin
          tap <= tap + 2'd1;
          if (tap == 2'd3) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          // hold here while an earlier result is still unclaimed
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid       <= 1'b1;
            out_ch.out_red     <= outside ? '0 : round_sat(acc_r);
            out_ch.out_green   <= outside ? '0 : round_sat(acc_g);
            out_ch.out_blue    <= outside ? '0 : round_sat(acc_b);
            out_ch.out_outside <= outside;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/bps_sample_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_sample_checker: result predictor and scoreboard for the pixel sampler
// Mirrors the image store and size registers, predicts the color of every
// accepted sample word and compares it with the returned word, field by field.
// ----------------------------------------------------------------------------
module bps_sample_checker
  import bps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  bps_in_if                    in_ch,
  bps_out_if                   out_ch,
  output int                   errors,
  output int                   pending
);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              is_outside;
  } color_t;

  localparam int ONE = 1 << FRAC_BITS;

  logic [PIX_W-1:0] pixel_mem [DEPTH];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  color_t           expected_colors [$];
  color_t           want;
  int               err_count = 0;

  assign errors = err_count;

  function automatic logic [ADDR_W-1:0] addr_of(int x, int y);
    return ADDR_W'(y * MAX_WIDTH + x);
  endfunction

  function automatic int chan_of(logic [PIX_W-1:0] px, int k);
    return int'(px >> (CHAN_W * (2 - k))) & 8'hFF;
  endfunction

  function automatic int clamp_chan(int v);
    return (v > 255) ? 255 : v;
  endfunction

  function automatic color_t predict_color(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy);
    color_t           c;
    int               w, h, x0, y0, dx, dy;
    logic [1:0]       k;
    int               res [3];
    logic [PIX_W-1:0] p00, p10, p01, p11;
    c = '0;
    w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    // sign bit set means a negative floor
    if (sx[COORD_W-1] || sy[COORD_W-1]) begin
      c.is_outside = 1'b1;
      return c;
    end
    x0 = int'(sx[COORD_W-2:FRAC_BITS]);
    y0 = int'(sy[COORD_W-2:FRAC_BITS]);
    dx = int'(sx[FRAC_BITS-1:0]);
    dy = int'(sy[FRAC_BITS-1:0]);
    if (x0 >= w || y0 >= h) begin
      c.is_outside = 1'b1;
      return c;
    end
    p00 = pixel_mem[addr_of(x0, y0)];
    for (k = 2'd0; k < 2'd3; k++) begin
      if (x0 == w - 1 && y0 == h - 1) begin
        res[k] = chan_of(p00, int'(k));
      end else if (x0 == w - 1) begin
        p01 = pixel_mem[addr_of(x0, y0 + 1)];
        res[k] = clamp_chan(((ONE - dy) * chan_of(p00, int'(k)) + dy * chan_of(p01, int'(k))
                             + ONE / 2) >> FRAC_BITS);
      end else if (y0 == h - 1) begin
        p10 = pixel_mem[addr_of(x0 + 1, y0)];
        res[k] = clamp_chan(((ONE - dx) * chan_of(p00, int'(k)) + dx * chan_of(p10, int'(k))
                             + ONE / 2) >> FRAC_BITS);
      end else begin
        p10 = pixel_mem[addr_of(x0 + 1, y0)];
        p01 = pixel_mem[addr_of(x0, y0 + 1)];
        p11 = pixel_mem[addr_of(x0 + 1, y0 + 1)];
        res[k] = clamp_chan(((ONE - dx) * (ONE - dy) * chan_of(p00, int'(k))
                             + dx * (ONE - dy) * chan_of(p10, int'(k))
                             + (ONE - dx) * dy * chan_of(p01, int'(k))
                             + dx * dy * chan_of(p11, int'(k))
                             + ONE * ONE / 2) >> (2 * FRAC_BITS));
      end
    end
    c.red   = CHAN_W'(res[0]);
    c.green = CHAN_W'(res[1]);
    c.blue  = CHAN_W'(res[2]);
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("%0t ns  mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [CHAN_W-1:0] got, logic [CHAN_W-1:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      expected_colors.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) width_reg = cfg_data;
        else if (cfg_index == CFG_HEIGHT) height_reg = cfg_data;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_colors.size() == 0) begin
          report_mismatch("result word with no sample pending");
        end else begin
          want = expected_colors.pop_front();
          check_field("out_red", out_ch.out_red, want.red);
          check_field("out_green", out_ch.out_green, want.green);
          check_field("out_blue", out_ch.out_blue, want.blue);
          check_field("out_outside", CHAN_W'(out_ch.out_outside), CHAN_W'(want.is_outside));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == OP_WRITE)
          pixel_mem[addr_of(int'(in_ch.pixel_x), int'(in_ch.pixel_y))] =
            {in_ch.pixel_red, in_ch.pixel_green, in_ch.pixel_blue};
        else
          expected_colors.push_back(predict_color(in_ch.sample_x, in_ch.sample_y));
      end
    end
    pending <= expected_colors.size();
  end

endmodule

// ----- tb/tb_bilinear_pixel_sampler_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilinear_pixel_sampler_unit: stimulus and verdict for the pixel sampler
// Fills the pixels each sample will read, adds stray writes, sweeps the image size through
// its extremes, and drives both channels with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_bilinear_pixel_sampler_unit;
  import bps_pkg::*;

  bit clk = 1'b0;
  bit rst = 1'b1;

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  bps_in_if  in_ch ();
  bps_out_if out_ch ();

  int errors;
  int pending;

  // Pixels written so far; a sample never reads a pixel outside this set.
  bit written [DEPTH];

  // Effective image size as the block sees it (saturated to the store).
  int eff_w = MAX_WIDTH;
  int eff_h = MAX_HEIGHT;

  // Back-to-back mode: no gaps on the sender, no stalls on the receiver.
  bit no_gaps = 1'b0;

  // Size sweep: tiny, single row/column, zero, saturating, full.
  // Entry 9 is drawn at run time.
  int phase_w [11] = '{4, 1, 256, 1, 0, 9, 2, 511, 16, 0, 300};
  int phase_h [11] = '{3, 1, 1, 256, 7, 0, 2, 511, 16, 0, 5};

  always #5 clk = ~clk;

  bilinear_pixel_sampler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  bps_sample_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .errors    (errors),
    .pending   (pending)
  );

  function automatic logic [ADDR_W-1:0] addr_of(int x, int y);
    return ADDR_W'(y * MAX_WIDTH + x);
  endfunction

  // Random color with a bias toward the channel extremes.
  function automatic logic [PIX_W-1:0] pick_color();
    logic [PIX_W-1:0] c;
    int               k, roll;
    c = PIX_W'($urandom);
    for (k = 0; k < 3; k++) begin
      roll = $urandom_range(0, 5);
      if (roll == 0) c[k*CHAN_W +: CHAN_W] = '0;
      else if (roll == 1) c[k*CHAN_W +: CHAN_W] = '1;
    end
    return c;
  endfunction

  // One coordinate: mostly inside an axis of length ext (edges favored),
  // some just past it, some anything at all (negative included).
  function automatic logic [COORD_W-1:0] pick_coord(int ext);
    logic [FRAC_BITS-1:0] frac;
    int                   roll, ip;
    roll = $urandom_range(0, 99);
    frac = FRAC_BITS'($urandom);
    if ($urandom_range(0, 7) == 0) frac = $urandom_range(0, 1) ? '1 : '0;
    if (roll < 82 && ext > 0) begin
      ip = (roll < 18) ? ext - 1 : $urandom_range(0, ext - 1);
      return {1'b0, INT_W'(ip), frac};
    end
    if (roll < 92 && ext < MAX_WIDTH) begin
      ip = $urandom_range(ext, MAX_WIDTH - 1);
      return {1'b0, INT_W'(ip), frac};
    end
    return COORD_W'($urandom);
  endfunction

  // Present one word on the command channel and hold it until taken.
  // Fields change at the falling edge; valid stays high across back-to-back words.
  task automatic send_word(logic op, logic [CHAN_W-1:0] px, logic [CHAN_W-1:0] py,
                           logic [PIX_W-1:0] color, logic [COORD_W-1:0] sx,
                           logic [COORD_W-1:0] sy);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.pixel_x     <= px;
    in_ch.pixel_y     <= py;
    in_ch.pixel_red   <= color[23:16];
    in_ch.pixel_green <= color[15:8];
    in_ch.pixel_blue  <= color[7:0];
    in_ch.sample_x    <= sx;
    in_ch.sample_y    <= sy;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
  endtask

  // Pixel write; the sample fields carry noise.
  task automatic put_pixel(int x, int y, logic [PIX_W-1:0] color);
    send_word(OP_WRITE, CHAN_W'(x), CHAN_W'(y), color, COORD_W'($urandom), COORD_W'($urandom));
    written[addr_of(x, y)] = 1'b1;
  endtask

  task automatic need_pixel(int x, int y);
    if (!written[addr_of(x, y)]) put_pixel(x, y, pick_color());
  endtask

  // Sample word, preceded by writes of any neighbor it reads that is still unset.
  // Neighbor set follows the edge rules: corner reads one pixel, right column
  // reads down, bottom row reads right, interior reads all four.
  task automatic sample_at(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy);
    int x0, y0;
    x0 = int'(sx[COORD_W-2:FRAC_BITS]);
    y0 = int'(sy[COORD_W-2:FRAC_BITS]);
    if (!sx[COORD_W-1] && !sy[COORD_W-1] && x0 < eff_w && y0 < eff_h) begin
      need_pixel(x0, y0);
      if (x0 != eff_w - 1) need_pixel(x0 + 1, y0);
      if (y0 != eff_h - 1) need_pixel(x0, y0 + 1);
      if (x0 != eff_w - 1 && y0 != eff_h - 1) need_pixel(x0 + 1, y0 + 1);
    end
    send_word(OP_SAMPLE, CHAN_W'($urandom), CHAN_W'($urandom), PIX_W'($urandom), sx, sy);
  endtask

  // Drain, let the pipe settle, then write both size registers.
  task automatic set_size(int w, int h);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= DIM_W'(w);
    @(negedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= DIM_W'(h);
    @(negedge clk);
    cfg_we    <= 1'b0;
    eff_w = (w > MAX_WIDTH) ? MAX_WIDTH : w;
    eff_h = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
  endtask

  // Result receiver: per word, stall a random number of cycles, then take it.
  // Ready is only touched once per falling edge, so a zero stall keeps it high.
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [3:0] ph;
    int         i;
    // every block input known from time zero
    cfg_we             = 1'b0;
    cfg_index          = CFG_WIDTH;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_WRITE;
    in_ch.pixel_x      = '0;
    in_ch.pixel_y      = '0;
    in_ch.pixel_red    = '0;
    in_ch.pixel_green  = '0;
    in_ch.pixel_blue   = '0;
    in_ch.sample_x     = '0;
    in_ch.sample_y     = '0;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed part, reset size 256x256 ----
    // top-left quad with extreme colors, so half weights exercise rounding
    put_pixel(0, 0, 24'hFFFFFF);
    put_pixel(1, 0, 24'h000000);
    put_pixel(0, 1, 24'hFF00FF);
    put_pixel(1, 1, 24'h00FF01);
    sample_at(17'h00000, 17'h00000);     // exact pixel, zero fraction
    sample_at(17'h00080, 17'h00080);     // half way in both axes
    sample_at(17'h000FF, 17'h000FF);     // largest fraction
    sample_at(17'h1FFFF, 17'h00010);     // negative x: outside
    sample_at(17'h00010, 17'h10000);     // most negative y: outside
    sample_at(17'h0FFFF, 17'h0FFFF);     // bottom-right corner pixel as is
    sample_at(17'h0FF80, 17'h00040);     // right column, vertical blend only
    sample_at(17'h00040, 17'h0FF80);     // bottom row, horizontal blend only

    // ---- random part: size sweep ----
    phase_w[9] = $urandom_range(1, 40);
    phase_h[9] = $urandom_range(1, 40);
    for (ph = 4'd0; ph < 4'd11; ph++) begin
      set_size(phase_w[ph], phase_h[ph]);
      no_gaps = (ph % 4'd3 == 4'd2);
      for (i = 0; i < 48; i++) begin
        // hold off once per phase until every result is back
        if (i == 27) begin
          in_ch.valid <= 1'b0;
          wait (pending == 0);
          @(negedge clk);
        end
        // stray writes anywhere in the store, inside or beyond the size
        if ($urandom_range(0, 7) == 0)
          put_pixel($urandom_range(0, MAX_WIDTH - 1), $urandom_range(0, MAX_HEIGHT - 1),
                    pick_color());
        sample_at(pick_coord(eff_w), pick_coord(eff_h));
      end
    end
    in_ch.valid <= 1'b0;

    // ---- wind down ----
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("tb_bilinear_pixel_sampler_unit: done, clean");
    else
      $display("tb_bilinear_pixel_sampler_unit: done, errors");
    $finish;
  end

  // Hard stop: well beyond the slowest legal run (all gaps and stalls at max).
  initial begin : watchdog
    #5000000;
    $display("tb_bilinear_pixel_sampler_unit: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
sv/bps_pkg.sv
sv/bps_in_if.sv
sv/bps_out_if.sv
sv/bilinear_pixel_sampler_unit.sv
tb/bps_sample_checker.sv
tb/tb_bilinear_pixel_sampler_unit.sv
